// ===== rtl/core/lsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the latency statistics collector.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int BUCKETS = 13;
  localparam int BKT_W   = 4;
  localparam int KIND_W  = 5;
  localparam int CAP_W   = 13;
  localparam int QDEPTH  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
  localparam logic [31:0]      ALL32     = 32'hFFFF_FFFF;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [KIND_W-1:0] K_COUNT  = 5'd0;
  localparam logic [KIND_W-1:0] K_MIN    = 5'd1;
  localparam logic [KIND_W-1:0] K_MAX    = 5'd2;
  localparam logic [KIND_W-1:0] K_AVG    = 5'd3;
  localparam logic [KIND_W-1:0] K_MEDIAN = 5'd4;
  localparam logic [KIND_W-1:0] K_P50    = 5'd5;
  localparam logic [KIND_W-1:0] K_P95    = 5'd6;
  localparam logic [KIND_W-1:0] K_P99    = 5'd7;
  localparam logic [KIND_W-1:0] K_P999   = 5'd8;
  localparam logic [KIND_W-1:0] K_STDDEV = 5'd9;
  localparam logic [KIND_W-1:0] K_BKT0   = 5'd10;
  localparam logic [KIND_W-1:0] K_LAST   = 5'd22;

  localparam logic [9:0] P95_MUL    = 10'd95;
  localparam logic [9:0] P99_MUL    = 10'd99;
  localparam logic [9:0] P999_MUL   = 10'd999;
  localparam logic [31:0] P999_MIN_N = 32'd1000;

  // floor(x / 100) = (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^32
  localparam logic [31:0] PCT_RECIP  = 32'd1374389535;
  localparam int          PCT_SHIFT  = 37;
  // floor(x / 1000) = (x * PMIL_RECIP) >> PMIL_SHIFT, exact for x below 2^32
  localparam logic [31:0] PMIL_RECIP = 32'd1099511628;
  localparam int          PMIL_SHIFT = 40;

  localparam logic [31:0] BUCKET_BOUND [BUCKETS-1] = '{
    32'd100, 32'd200, 32'd500, 32'd1000, 32'd2000, 32'd5000, 32'd10000,
    32'd20000, 32'd50000, 32'd100000, 32'd500000, 32'd1000000
  };

  typedef struct packed {
    logic             req_report;
    logic [31:0]      sample;
    logic [BKT_W-1:0] bucket;
  } item_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] x);
    logic [BKT_W-1:0] b;
    b = BKT_W'(BUCKETS - 1);
    for (int i = BUCKETS - 2; i >= 0; i--) begin
      if (x < BUCKET_BOUND[i]) begin
        b = BKT_W'(i);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/latency_stats_collector_top.sv =====
// Samples: one request per cycle while the request queue is not full; a sample
//   passes through the four-entry request queue into the statistics registers.
// Report: in-place sort on the sample RAM, two divides, a variance pass over the
//   stored samples and a square root; 23 results.
// Reset clears counts, sum, min/max, histogram and sets capacity to 4096;
//   the sample RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// latency_stats_collector_top
// Latency histogram and percentile monitor.
// ----------------------------------------------------------------------------
module latency_stats_collector_top import lsc_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_req_type,
  input  wire logic [31:0]       in_lat_ns,
  output logic                   empty,
  input  wire logic              pop,
  output logic [KIND_W-1:0]      out_stat_kind,
  output logic [31:0]            out_stat_value,
  output logic                   out_last_item,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data
);

  logic  q_empty;
  logic  q_pop;
  item_t q_head;

  lsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .req_type  (in_req_type),
    .lat_ns    (in_lat_ns),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_head    (q_head)
  );

  lsc_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_empty   (empty),
    .out_pop     (pop),
    .out_kind    (out_stat_kind),
    .out_value   (out_stat_value),
    .out_last    (out_last_item)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_front
// Accepts requests, sorts samples into histogram buckets and queues them.
// ----------------------------------------------------------------------------
module lsc_front import lsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type,
  input  wire logic [31:0] lat_ns,
  input  wire logic        q_pop,
  output logic             q_empty,
  output item_t            q_head
);

  localparam int QAW = $clog2(QDEPTH);

  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           wr;
  logic           rd;
  item_t          item;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign wr      = push && !full;
  assign rd      = q_pop && !q_empty;
  assign q_head  = q_r[rd_ptr_r];

  always_comb begin
    item.req_report = req_type;
    item.sample     = lat_ns;
    item.bucket     = bucket_of(lat_ns);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsc_div #(
  parameter int DW = 141,
  parameter int VW = 77
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot
);

  localparam int CW = $clog2(DW);

  logic [VW:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r[VW-1:0], quo_r[DW-1]};
  assign fits    = (shifted >= {1'b0, dv_r});
  assign done    = done_r;
  assign quot    = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, dv_r}) : shifted;
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_back
// Applies queued requests: updates running statistics on a sample, and on a
// report sorts the stored samples, derives percentiles, average and standard
// deviation, then hands out the results one at a time.
// ----------------------------------------------------------------------------
module lsc_back import lsc_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,
  input  wire logic              q_empty,
  input  wire item_t             q_head,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [KIND_W-1:0]      out_kind,
  output logic [31:0]            out_value,
  output logic                   out_last
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int KW  = 64 + NW;
  localparam int ACW = 128 + NW;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_SRT_RD0 = 6'd1;
  localparam logic [5:0] S_SRT_CUR = 6'd2;
  localparam logic [5:0] S_SRT_RD  = 6'd3;
  localparam logic [5:0] S_SRT_CMP = 6'd4;
  localparam logic [5:0] S_SRT_END = 6'd5;
  localparam logic [5:0] S_AVG     = 6'd6;
  localparam logic [5:0] S_AVG_W   = 6'd7;
  localparam logic [5:0] S_MED_RD  = 6'd8;
  localparam logic [5:0] S_MED     = 6'd9;
  localparam logic [5:0] S_PDIV    = 6'd10;
  localparam logic [5:0] S_PWAIT   = 6'd11;
  localparam logic [5:0] S_PRD     = 6'd12;
  localparam logic [5:0] S_PGET    = 6'd13;
  localparam logic [5:0] S_SD_RD   = 6'd14;
  localparam logic [5:0] S_SD_P    = 6'd15;
  localparam logic [5:0] S_SD_D    = 6'd16;
  localparam logic [5:0] S_SD_M0   = 6'd17;
  localparam logic [5:0] S_SD_M1   = 6'd18;
  localparam logic [5:0] S_SD_M2   = 6'd19;
  localparam logic [5:0] S_SD_M3   = 6'd20;
  localparam logic [5:0] S_SD_ACC  = 6'd21;
  localparam logic [5:0] S_K0      = 6'd22;
  localparam logic [5:0] S_K1      = 6'd23;
  localparam logic [5:0] S_K2      = 6'd24;
  localparam logic [5:0] S_K3      = 6'd25;
  localparam logic [5:0] S_K4      = 6'd26;
  localparam logic [5:0] S_QDIV    = 6'd27;
  localparam logic [5:0] S_QWAIT   = 6'd28;
  localparam logic [5:0] S_SQ      = 6'd29;
  localparam logic [5:0] S_EMIT    = 6'd30;
  localparam logic [5:0] S_PSHF    = 6'd31;

  // control and running statistics
  logic [5:0]        state_r;
  logic [CAP_W-1:0]  cap_r;
  logic [31:0]       count_r;
  logic [63:0]       sum_r;
  logic [31:0]       min_r;
  logic [31:0]       max_r;
  logic [31:0]       bucket_r [BUCKETS];
  logic [KIND_W-1:0] kind_r;
  logic [1:0]        pk_r;
  logic [4:0]        sq_cnt_r;

  // report datapath
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     plen_r;
  logic [NW-1:0]     j_r;
  logic [NW-1:0]     i_r;
  logic [AW-1:0]     idx_r;
  logic [31:0]       cur_r;
  logic [31:0]       avg_r;
  logic [31:0]       med_r;
  logic [31:0]       pct_r [3];
  logic [31:0]       sd_r;
  logic [63:0]       mres_r;
  logic [63:0]       diff_r;
  logic [127:0]      sq_r;
  logic [ACW-1:0]    acc_r;
  logic [63:0]       csq_r;
  logic [KW-1:0]     k_r;
  logic [63:0]       sq_q_r;
  logic [32:0]       sq_rem_r;
  logic [31:0]       sq_root_r;

  logic              take;
  logic              is_add;
  logic [31:0]       capeff;
  logic [31:0]       n32;
  logic [64:0]       sum_add;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic [31:0]       sort_lo;
  logic [31:0]       sort_hi;
  logic [NW-1:0]     nm1;
  logic [NW-1:0]     half_n;
  logic [NW-1:0]     jm1;
  logic [NW-1:0]     plm1;
  logic [9:0]        pmul;
  logic [31:0]       precip;
  logic              p999_small;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic              div_start;
  logic [ACW-1:0]    div_dividend;
  logic [KW-1:0]     div_divisor;
  logic              div_done;
  logic [ACW-1:0]    div_quot;
  logic [34:0]       sq_remsh;
  logic [34:0]       sq_trial;
  logic              sq_fit;
  logic [31:0]       sq_root_nxt;
  logic [BKT_W-1:0]  bidx;

  assign take    = (state_r == S_IDLE) && !q_empty;
  assign is_add  = (q_head.req_report == REQ_ADD);
  assign q_pop   = take;
  assign sum_add = {1'b0, sum_r} + 65'(q_head.sample);

  always_comb begin
    if (cap_r == '0) begin
      capeff = 32'd1;
    end else if (32'(cap_r) > 32'(MAX_SAMPLES)) begin
      capeff = 32'(MAX_SAMPLES);
    end else begin
      capeff = 32'(cap_r);
    end
    n32 = (count_r < capeff) ? count_r : capeff;
  end

  assign nm1     = n_r - NW'(1);
  assign half_n  = n_r >> 1;
  assign jm1     = j_r - NW'(1);
  assign plm1    = plen_r - NW'(1);
  assign sort_lo = (cur_r < ram_rdata) ? cur_r : ram_rdata;
  assign sort_hi = (cur_r < ram_rdata) ? ram_rdata : cur_r;

  always_comb begin
    unique case (pk_r)
      2'd0:    begin pmul = P95_MUL;  precip = PCT_RECIP;  end
      2'd1:    begin pmul = P99_MUL;  precip = PCT_RECIP;  end
      default: begin pmul = P999_MUL; precip = PMIL_RECIP; end
    endcase
  end

  assign p999_small = (pk_r == 2'd2) && (32'(n_r) <= P999_MIN_N);

  // sample store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = q_head.sample;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE:    ram_we = take && is_add && (count_r < capeff);
      S_SRT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = jm1[AW-1:0];
        ram_wdata = sort_lo;
      end
      S_SRT_END: begin
        ram_we    = 1'b1;
        ram_waddr = plm1[AW-1:0];
        ram_wdata = cur_r;
      end
      S_SRT_RD:  ram_raddr = j_r[AW-1:0];
      S_MED_RD:  ram_raddr = half_n[AW-1:0];
      S_PRD:     ram_raddr = idx_r;
      S_SD_RD:   ram_raddr = i_r[AW-1:0];
      default:   ram_raddr = '0;
    endcase
  end

  lsc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared 32x32 multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PDIV:  begin mul_a = 32'(n_r);       mul_b = 32'(pmul);      end
      S_PWAIT: begin mul_a = mres_r[31:0];   mul_b = precip;         end
      S_SD_P:  begin mul_a = count_r;        mul_b = ram_rdata;      end
      S_SD_M0: begin mul_a = diff_r[31:0];   mul_b = diff_r[31:0];   end
      S_SD_M1: begin mul_a = diff_r[63:32];  mul_b = diff_r[31:0];   end
      S_SD_M2: begin mul_a = diff_r[63:32];  mul_b = diff_r[63:32];  end
      S_K0:    begin mul_a = count_r;        mul_b = count_r;        end
      S_K2:    begin mul_a = csq_r[31:0];    mul_b = 32'(n_r);       end
      S_K3:    begin mul_a = csq_r[63:32];   mul_b = 32'(n_r);       end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = ACW'(sum_r);
    div_divisor  = KW'(count_r);
    unique case (state_r)
      S_AVG:   div_start = 1'b1;
      S_QDIV:  begin
        div_start    = 1'b1;
        div_dividend = acc_r;
        div_divisor  = k_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  lsc_div #(
    .DW (ACW),
    .VW (KW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // one result bit per square root step, from two bits of the radicand
  assign sq_remsh    = {sq_rem_r, sq_q_r[63:62]};
  assign sq_trial    = {1'b0, sq_root_r, 2'b01};
  assign sq_fit      = (sq_remsh >= sq_trial);
  assign sq_root_nxt = {sq_root_r[30:0], sq_fit};

  always_ff @(posedge clk) begin
    mres_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= CAP_RESET;
      count_r  <= '0;
      sum_r    <= '0;
      min_r    <= ALL32;
      max_r    <= '0;
      kind_r   <= '0;
      pk_r     <= '0;
      sq_cnt_r <= '0;
      for (int b = 0; b < BUCKETS; b++) begin
        bucket_r[b] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          kind_r <= '0;
          if (take && is_add) begin
            if (count_r != ALL32) begin
              count_r <= count_r + 1'b1;
            end
            sum_r <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
            if (q_head.sample < min_r) begin
              min_r <= q_head.sample;
            end
            if (q_head.sample > max_r) begin
              max_r <= q_head.sample;
            end
            if (bucket_r[q_head.bucket] != ALL32) begin
              bucket_r[q_head.bucket] <= bucket_r[q_head.bucket] + 1'b1;
            end
          end else if (take) begin
            n_r    <= n32[NW-1:0];
            plen_r <= n32[NW-1:0];
            if (count_r == '0) begin
              avg_r    <= '0;
              med_r    <= '0;
              pct_r[0] <= '0;
              pct_r[1] <= '0;
              pct_r[2] <= '0;
              sd_r     <= '0;
              state_r  <= S_EMIT;
            end else if (n32 >= 32'd2) begin
              state_r <= S_SRT_RD0;
            end else begin
              state_r <= S_AVG;
            end
          end
        end
        // bubble pass: carry the larger value up, write the smaller back
        S_SRT_RD0: state_r <= S_SRT_CUR;
        S_SRT_CUR: begin
          cur_r   <= ram_rdata;
          j_r     <= NW'(1);
          state_r <= S_SRT_RD;
        end
        S_SRT_RD:  state_r <= S_SRT_CMP;
        S_SRT_CMP: begin
          cur_r <= sort_hi;
          if (j_r == plm1) begin
            state_r <= S_SRT_END;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SRT_RD;
          end
        end
        S_SRT_END: begin
          plen_r <= plm1;
          if (plen_r > NW'(2)) begin
            state_r <= S_SRT_RD0;
          end else begin
            state_r <= S_AVG;
          end
        end
        S_AVG:     state_r <= S_AVG_W;
        S_AVG_W: begin
          if (div_done) begin
            avg_r   <= (div_quot > ACW'(ALL32)) ? ALL32 : div_quot[31:0];
            state_r <= S_MED_RD;
          end
        end
        S_MED_RD:  state_r <= S_MED;
        S_MED: begin
          med_r   <= ram_rdata;
          pk_r    <= '0;
          state_r <= S_PDIV;
        end
        // percentile index: n times the percentage, then a reciprocal multiply
        S_PDIV: begin
          if (p999_small) begin
            idx_r   <= nm1[AW-1:0];
            state_r <= S_PRD;
          end else begin
            state_r <= S_PWAIT;
          end
        end
        S_PWAIT:   state_r <= S_PSHF;
        S_PSHF: begin
          if (pk_r == 2'd2) begin
            idx_r <= mres_r[PMIL_SHIFT +: AW];
          end else begin
            idx_r <= mres_r[PCT_SHIFT +: AW];
          end
          state_r <= S_PRD;
        end
        S_PRD:     state_r <= S_PGET;
        S_PGET: begin
          pct_r[pk_r] <= ram_rdata;
          if (pk_r == 2'd2) begin
            i_r     <= '0;
            acc_r   <= '0;
            state_r <= S_SD_RD;
          end else begin
            pk_r    <= pk_r + 1'b1;
            state_r <= S_PDIV;
          end
        end
        S_SD_RD:   state_r <= S_SD_P;
        S_SD_P:    state_r <= S_SD_D;
        S_SD_D: begin
          diff_r  <= (mres_r > sum_r) ? (mres_r - sum_r) : (sum_r - mres_r);
          state_r <= S_SD_M0;
        end
        S_SD_M0:   state_r <= S_SD_M1;
        S_SD_M1: begin
          sq_r    <= {64'd0, mres_r};
          state_r <= S_SD_M2;
        end
        S_SD_M2: begin
          sq_r    <= sq_r + ({64'd0, mres_r} << 33);
          state_r <= S_SD_M3;
        end
        S_SD_M3: begin
          sq_r    <= sq_r + ({64'd0, mres_r} << 64);
          state_r <= S_SD_ACC;
        end
        S_SD_ACC: begin
          acc_r <= acc_r + ACW'(sq_r);
          if (i_r == nm1) begin
            state_r <= S_K0;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SD_RD;
          end
        end
        // divisor: count squared times stored samples
        S_K0:      state_r <= S_K1;
        S_K1: begin
          csq_r   <= mres_r;
          state_r <= S_K2;
        end
        S_K2:      state_r <= S_K3;
        S_K3: begin
          k_r     <= KW'(mres_r);
          state_r <= S_K4;
        end
        S_K4: begin
          k_r     <= k_r + (KW'(mres_r) << 32);
          state_r <= S_QDIV;
        end
        S_QDIV:    state_r <= S_QWAIT;
        S_QWAIT: begin
          if (div_done) begin
            if (div_quot[ACW-1:64] != '0) begin
              sd_r    <= ALL32;
              state_r <= S_EMIT;
            end else begin
              sq_q_r    <= div_quot[63:0];
              sq_rem_r  <= '0;
              sq_root_r <= '0;
              sq_cnt_r  <= '0;
              state_r   <= S_SQ;
            end
          end
        end
        S_SQ: begin
          sq_rem_r  <= sq_fit ? 33'(sq_remsh - sq_trial) : sq_remsh[32:0];
          sq_root_r <= sq_root_nxt;
          sq_q_r    <= {sq_q_r[61:0], 2'b00};
          sq_cnt_r  <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'd31) begin
            sd_r    <= sq_root_nxt;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_pop) begin
            if (kind_r == K_LAST) begin
              state_r <= S_IDLE;
            end else begin
              kind_r <= kind_r + 1'b1;
            end
          end
        end
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  assign bidx      = BKT_W'(kind_r - K_BKT0);
  assign out_empty = (state_r != S_EMIT);
  assign out_kind  = kind_r;
  assign out_last  = (kind_r == K_LAST);

  always_comb begin
    unique case (kind_r)
      K_COUNT:         out_value = count_r;
      K_MIN:           out_value = min_r;
      K_MAX:           out_value = max_r;
      K_AVG:           out_value = avg_r;
      K_MEDIAN, K_P50: out_value = med_r;
      K_P95:           out_value = pct_r[0];
      K_P99:           out_value = pct_r[1];
      K_P999:          out_value = pct_r[2];
      K_STDDEV:        out_value = sd_r;
      default:         out_value = bucket_r[bidx];
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/sv/lsc_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_stats_checker
// Watches the sample, report and capacity ports of the latency statistics
// collector, keeps its own copy of the running statistics and sample store,
// predicts the 23 results of every report request and compares them with
// what the block pops.
// ----------------------------------------------------------------------------
module lsc_stats_checker import lsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  logic              in_req_type,
  input  logic [31:0]       in_lat_ns,
  input  logic              empty,
  input  logic              pop,
  input  logic [KIND_W-1:0] out_stat_kind,
  input  logic [31:0]       out_stat_value,
  input  logic              out_last_item,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  output int                fail_count,
  output int                stats_pending
);

  localparam int MAX_SAMPLES = 4096;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [31:0]       value;
    logic              last;
  } stat_t;

  stat_t       stats_q [$];
  logic [31:0] store_mem [0:MAX_SAMPLES-1];
  logic [31:0] cnt;
  logic [63:0] sum;
  logic [31:0] min_v;
  logic [31:0] max_v;
  logic [31:0] bkt_cnt [BUCKETS];
  logic [CAP_W-1:0] cap;

  assign stats_pending = stats_q.size();

  function automatic int eff_cap();
    int c;
    c = int'(cap);
    if (c == 0) begin
      c = 1;
    end
    if (c > MAX_SAMPLES) begin
      c = MAX_SAMPLES;
    end
    return c;
  endfunction

  // Floor root of the mean squared deviation, scaled by the count to stay exact
  function automatic logic [31:0] std_dev(int n);
    logic [191:0] acc;
    logic [191:0] lhs;
    logic [63:0]  p;
    logic [63:0]  d;
    logic [63:0]  rc;
    logic [31:0]  r;
    logic [31:0]  cand;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      p = 64'(cnt) * 64'(store_mem[i]);
      d = (p > sum) ? p - sum : sum - p;
      acc = acc + 192'(d) * 192'(d);
    end
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (32'd1 << b);
      rc = 64'(cand) * 64'(cnt);
      lhs = 192'(rc) * 192'(rc) * 192'(n);
      if (lhs <= acc) begin
        r = cand;
      end
    end
    return r;
  endfunction

  task automatic add_sample(logic [31:0] x);
    int b;
    if (cnt < 32'(eff_cap())) begin
      store_mem[cnt] = x;
    end
    if (cnt != ALL32) begin
      cnt++;
    end
    if (sum > ~64'd0 - 64'(x)) begin
      sum = ~64'd0;
    end else begin
      sum = sum + 64'(x);
    end
    if (x < min_v) begin
      min_v = x;
    end
    if (x > max_v) begin
      max_v = x;
    end
    b = BUCKETS - 1;
    for (int i = BUCKETS - 2; i >= 0; i--) begin
      if (x < BUCKET_BOUND[i]) begin
        b = i;
      end
    end
    if (bkt_cnt[b] != ALL32) begin
      bkt_cnt[b]++;
    end
  endtask

  task automatic predict_report();
    logic [31:0] v [10+BUCKETS];
    logic [63:0] avg;
    logic [31:0] t;
    int n;
    int j;
    stat_t s;
    foreach (v[k]) begin
      v[k] = '0;
    end
    v[K_COUNT] = cnt;
    v[K_MIN]   = min_v;
    v[K_MAX]   = max_v;
    if (cnt != 0) begin
      n = (cnt < 32'(eff_cap())) ? int'(cnt) : eff_cap();
      avg = sum / 64'(cnt);
      v[K_AVG] = (avg > 64'(ALL32)) ? ALL32 : avg[31:0];
      // sort in place: later reports see the reordered store
      for (int i = 1; i < n; i++) begin
        t = store_mem[i];
        j = i - 1;
        while (j >= 0 && store_mem[j] > t) begin
          store_mem[j+1] = store_mem[j];
          j--;
        end
        store_mem[j+1] = t;
      end
      v[K_MEDIAN] = store_mem[n / 2];
      v[K_P50]    = store_mem[(n * 50) / 100];
      v[K_P95]    = store_mem[(n * 95) / 100];
      v[K_P99]    = store_mem[(n * 99) / 100];
      v[K_P999]   = store_mem[(n > 1000) ? (n * 999) / 1000 : n - 1];
      v[K_STDDEV] = std_dev(n);
    end
    for (int k = 0; k < BUCKETS; k++) begin
      v[int'(K_BKT0) + k] = bkt_cnt[k];
    end
    for (int k = 0; k < 10 + BUCKETS; k++) begin
      s.kind  = KIND_W'(k);
      s.value = v[k];
      s.last  = (KIND_W'(k) == K_LAST);
      stats_q.push_back(s);
    end
  endtask

  task automatic report_bad(string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    stat_t e;
    if (!rst_n) begin
      cnt   = '0;
      sum   = '0;
      min_v = ALL32;
      max_v = '0;
      foreach (bkt_cnt[k]) begin
        bkt_cnt[k] = '0;
      end
      cap = CAP_RESET;
      stats_q.delete();
    end else begin
      if (pop && !empty) begin
        if (stats_q.size() == 0) begin
          report_bad($sformatf("unexpected result kind %0d value %0d",
                               out_stat_kind, out_stat_value));
        end else begin
          e = stats_q.pop_front();
          if (out_stat_kind !== e.kind || out_stat_value !== e.value ||
              out_last_item !== e.last) begin
            report_bad($sformatf({"stat mismatch: exp kind %0d value %0d last %0b,",
                                  " got kind %0d value %0d last %0b"},
                                 e.kind, e.value, e.last,
                                 out_stat_kind, out_stat_value, out_last_item));
          end
        end
      end
      if (push && !full) begin
        if (in_req_type == REQ_REPORT) begin
          predict_report();
        end else begin
          add_sample(in_lat_ns);
        end
      end
      if (cfg_wr_en) begin
        cap = cfg_wr_data;
      end
    end
  end

  initial begin
    fail_count = 0;
  end

endmodule

// ===== tb/sv/tb_latency_stats_collector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latency_stats_collector_top
// Drives sample and report requests with random gaps and result stalls,
// moves the sample capacity between phases and leaves checking to the
// statistics checker.
// ----------------------------------------------------------------------------
module tb_latency_stats_collector_top;
  import lsc_pkg::*;

  localparam int WDOG_LIMIT = 1000000;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  logic              in_req_type;
  logic [31:0]       in_lat_ns;
  logic              empty;
  logic              pop;
  logic [KIND_W-1:0] out_stat_kind;
  logic [31:0]       out_stat_value;
  logic              out_last_item;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;
  int                fail_count;
  int                stats_pending;

  // sender-side view used to keep every store read within written entries
  int n_added;
  int n_written;
  int cur_cap;
  int n_sent;
  int idle_cycles;

  latency_stats_collector_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_lat_ns      (in_lat_ns),
    .empty          (empty),
    .pop            (pop),
    .out_stat_kind  (out_stat_kind),
    .out_stat_value (out_stat_value),
    .out_last_item  (out_last_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  lsc_stats_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_lat_ns      (in_lat_ns),
    .empty          (empty),
    .pop            (pop),
    .out_stat_kind  (out_stat_kind),
    .out_stat_value (out_stat_value),
    .out_last_item  (out_last_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .stats_pending  (stats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic kind, logic [31:0] x);
    int gap;
    push        <= 1'b1;
    in_req_type <= kind;
    in_lat_ns   <= x;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    n_sent++;
    if (kind == REQ_ADD) begin
      if (n_added < cur_cap && n_added == n_written) begin
        n_written++;
      end
      n_added++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold until every result is out and queued samples have settled
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (stats_pending != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    int e;
    drain();
    e = int'(c);
    if (e == 0) begin
      e = 1;
    end
    if (e > 4096) begin
      e = 4096;
    end
    cur_cap     = e;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      return $urandom_range(0, 1200000);
    end else if (r == 1) begin
      return $urandom();
    end
    return BUCKET_BOUND[$urandom_range(0, BUCKETS - 2)] + $urandom_range(0, 2) - 1;
  endfunction

  // result side: mostly short stalls, a few long ones, some clean stretches
  initial begin
    int stall;
    int clean;
    pop   <= 1'b0;
    stall = 0;
    clean = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (clean > 0) begin
          clean--;
        end else if ($urandom_range(0, 49) == 0) begin
          clean = $urandom_range(20, 80);
        end else if ($urandom_range(0, 3) == 0) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) :
                                                $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int reps;
    int adds;
    int wp;
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_req_type  <= REQ_ADD;
    in_lat_ns    <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    idle_cycles  <= 0;
    n_added   = 0;
    n_written = 0;
    n_sent    = 0;
    cur_cap   = 4096;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty report, then every bucket edge and both ends of the range
    send(REQ_REPORT, $urandom());
    send(REQ_ADD, 32'd0);
    for (int i = 0; i < BUCKETS - 1; i++) begin
      send(REQ_ADD, BUCKET_BOUND[i] - 32'd1);
    end
    send(REQ_ADD, BUCKET_BOUND[BUCKETS-2]);
    send(REQ_ADD, ALL32);
    send(REQ_REPORT, '0);

    // capacity above the store size, then zero
    set_capacity('1);
    repeat (4) send(REQ_ADD, rand_sample());
    send(REQ_REPORT, ALL32);
    set_capacity('0);
    repeat (3) send(REQ_ADD, rand_sample());
    send(REQ_REPORT, '0);

    while (n_sent < 285) begin
      // keep the capacity inside the written part of the store
      wp = (n_written > 0) ? n_written : 1;
      if (n_added <= n_written) begin
        wp = 4096;
      end
      case ($urandom_range(0, 3))
        0: set_capacity(CAP_W'(1));
        1: set_capacity(CAP_W'(wp));
        default: set_capacity(CAP_W'($urandom_range(1, wp)));
      endcase
      reps = $urandom_range(1, 5);
      for (int r = 0; r < reps; r++) begin
        adds = $urandom_range(0, 12);
        for (int a = 0; a < adds; a++) begin
          send(REQ_ADD, rand_sample());
        end
        send(REQ_REPORT, $urandom());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
